>>> design/b27_pkg.sv
// ----------------------------------------------------------------------------
// b27_pkg
// Shared constants, power-of-27 multiple table and controller/datapath
// command and status types for the base-27 letter converter.
// ----------------------------------------------------------------------------
package b27_pkg;

    localparam int MAX_DIGITS = 13;
    localparam int VALUE_W    = 64;
    localparam int RADIX      = 27;
    localparam int DIGIT_W    = 5;
    localparam int POS_W      = $clog2(MAX_DIGITS + 1);
    localparam int MULT_W     = VALUE_W + DIGIT_W;
    localparam int CHAR_W     = 7;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd95;
    localparam logic [CHAR_W-1:0] CHAR_BASE = 7'd64;
    localparam logic [CHAR_W-1:0] CHAR_Z    = 7'd90;

    // character source for an emitted beat
    localparam logic [1:0] SRC_DIGIT = 2'd0;
    localparam logic [1:0] SRC_ZERO  = 2'd1;
    localparam logic [1:0] SRC_Z     = 2'd2;

    // k * 27^d for every digit position d and nonzero digit value k
    typedef logic [MAX_DIGITS:0][RADIX-1:1][MULT_W-1:0] mult_tab_t;

    function automatic mult_tab_t build_mult_tab();
        mult_tab_t          t;
        logic [MULT_W-1:0]  p;
        p = MULT_W'(1);
        for (int d = 0; d <= MAX_DIGITS; d++)
        begin
            for (int k = 1; k < RADIX; k++)
            begin
                t[d][k] = p * MULT_W'(k);
            end
            p = p * MULT_W'(RADIX);
        end
        return t;
    endfunction

    localparam mult_tab_t MULT_TAB = build_mult_tab();
    localparam logic [VALUE_W-1:0] LIMIT = MULT_TAB[MAX_DIGITS][1][VALUE_W-1:0];

    typedef struct packed {
        logic       load;
        logic       load_ovf;
        logic       step;
        logic       emit;
        logic [1:0] src;
        logic       last;
        logic       ovf;
    } dp_cmd_t;

    typedef struct packed {
        logic over_limit;
        logic pos_zero;
        logic started;
        logic digit_nz;
        logic room;
    } dp_status_t;

endpackage

>>> design/base27_number_to_letters_unit.sv
// ----------------------------------------------------------------------------
// base27_number_to_letters_unit
// Converts a 64-bit unsigned value to its base-27 letter string, one ASCII
// character per output beat, most significant digit first.
// ----------------------------------------------------------------------------
//  channel | signals                                  | dir | beat
//  --------+------------------------------------------+-----+-------------------
//  in      | in_valid, in_ready, value[63:0]          | in  | one value
//  out     | out_valid, out_ready, char_code[6:0],    | out | one character
//          | last_char, overflow                      |     |
//
//  a value is accepted from idle, then one digit position per cycle from 27^13
//  down to 27^0, where a digit to emit waits for room in the output register;
//  a one-digit value gets an underscore prefix beat before its letter.
//  overflow values give a string of thirteen Z characters.
//  each digit step rests on the parallel trial subtraction of all multiples.
//  in_ready is high only between values; a full output register stalls beats.
//  reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module base27_number_to_letters_unit
    import b27_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [VALUE_W-1:0]  value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CHAR_W-1:0]   char_code,
    output logic                last_char,
    output logic                overflow
);

    dp_cmd_t    cmd;
    dp_status_t status;

    b27_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    b27_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .char_code (char_code),
        .last_char (last_char),
        .overflow  (overflow)
    );

endmodule

>>> design/b27_datapath.sv
// ----------------------------------------------------------------------------
// b27_datapath
// Remainder and position registers, combinational digit extraction against the
// constant multiples of the current power, and the output beat register.
// ----------------------------------------------------------------------------
module b27_datapath
    import b27_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [VALUE_W-1:0]   value,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [CHAR_W-1:0]    char_code,
    output logic                 last_char,
    output logic                 overflow
);

    logic [VALUE_W-1:0]  rem_reg,     rem_next;
    logic [POS_W-1:0]    pos_reg,     pos_next;
    logic                started_reg, started_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   char_reg,    char_next;
    logic                last_reg,    last_next;
    logic                ovf_reg,     ovf_next;

    logic [MULT_W-1:0]   rem_ext;
    logic [MULT_W-1:0]   diff     [RADIX-1:1];
    logic [DIGIT_W-1:0]  digit;
    logic [VALUE_W-1:0]  rem_sub;
    logic [CHAR_W-1:0]   letter;
    logic                room;

    assign rem_ext = MULT_W'(rem_reg);

    // all trial subtractions in parallel, the largest one without borrow wins
    always_comb
    begin
        digit   = '0;
        rem_sub = rem_reg;
        for (int k = 1; k < RADIX; k++)
        begin
            diff[k] = rem_ext - MULT_TAB[pos_reg][k];
            if (rem_ext >= MULT_TAB[pos_reg][k])
            begin
                digit   = DIGIT_W'(k);
                rem_sub = diff[k][VALUE_W-1:0];
            end
        end
    end

    assign letter = (digit == '0) ? CHAR_ZERO : CHAR_BASE + CHAR_W'(digit);
    assign room   = !out_valid_reg || out_ready;

    always_comb
    begin
        rem_next     = rem_reg;
        pos_next     = pos_reg;
        started_next = started_reg;
        if (cmd.load)
        begin
            rem_next     = value;
            pos_next     = cmd.load_ovf ? POS_W'(MAX_DIGITS - 1) : POS_W'(MAX_DIGITS);
            started_next = 1'b0;
        end
        else if (cmd.step)
        begin
            rem_next     = rem_sub;
            pos_next     = pos_reg - POS_W'(1);
            started_next = started_reg || (digit != '0);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        ovf_next       = ovf_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            last_next      = cmd.last;
            ovf_next       = cmd.ovf;
            case (cmd.src)
                SRC_DIGIT: char_next = letter;
                SRC_Z:     char_next = CHAR_Z;
                default:   char_next = CHAR_ZERO;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            pos_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            pos_reg       <= pos_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
            ovf_reg       <= ovf_next;
        end
    end

    assign status.over_limit = (value > LIMIT);
    assign status.pos_zero   = (pos_reg == '0);
    assign status.started    = started_reg;
    assign status.digit_nz   = (digit != '0);
    assign status.room       = room;

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;
    assign overflow  = ovf_reg;

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> room)
        else $error("beat written while output register still full");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_DIGITS))
        else $error("digit position out of range");

    a_ovf_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ovf_reg |-> char_reg == CHAR_Z)
        else $error("overflow beat without Z");

    a_no_step_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (pos_reg != '0) || cmd.emit)
        else $error("position stepped below zero without a final beat");

endmodule

>>> design/b27_ctrl.sv
// ----------------------------------------------------------------------------
// b27_ctrl
// Sequencer: walks the digit positions from the top down, skips leading
// zeros, handles the single-digit prefix and the all-Z overflow string.
// ----------------------------------------------------------------------------
module b27_ctrl
    import b27_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  dp_status_t  status,
    output dp_cmd_t     cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PAD  = 2'd2;
    localparam logic [1:0] S_OVF  = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.src      = SRC_DIGIT;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    cmd.load_ovf = status.over_limit;
                    state_next   = status.over_limit ? S_OVF : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.pos_zero && !status.started)
                begin
                    // value below 27: underscore first, then the letter if any
                    if (status.room)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.src    = SRC_ZERO;
                        cmd.last   = !status.digit_nz;
                        state_next = status.digit_nz ? S_PAD : S_IDLE;
                    end
                end
                else if (status.started || status.digit_nz)
                begin
                    if (status.room)
                    begin
                        cmd.emit = 1'b1;
                        cmd.last = status.pos_zero;
                        // position stays at zero after the final digit
                        cmd.step = !status.pos_zero;
                        if (status.pos_zero)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    // leading zero digit
                    cmd.step = 1'b1;
                end
            end
            S_PAD:
            begin
                if (status.room)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_OVF:
            begin
                if (status.room)
                begin
                    cmd.emit = 1'b1;
                    cmd.src  = SRC_Z;
                    cmd.ovf  = 1'b1;
                    cmd.last = status.pos_zero;
                    cmd.step = !status.pos_zero;
                    if (status.pos_zero)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> in_valid && in_ready)
        else $error("value loaded outside an accepted beat");

    a_pad_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PAD && $past(state_reg) != S_PAD |-> $past(state_reg) == S_SCAN)
        else $error("prefix state entered from wrong state");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives values into the base-27 letter converter and scores every output
// character against typed directed strings or a model of the radix-27 conversion,
// with random gaps on the input side and random back pressure on the output side.
// ----------------------------------------------------------------------------
module tb_top;

    import b27_pkg::VALUE_W;
    import b27_pkg::CHAR_W;

    localparam logic [CHAR_W-1:0] LETTER_OFFSET = 7'd64;
    localparam logic [CHAR_W-1:0] UNDERSCORE    = 7'd95;
    localparam logic [CHAR_W-1:0] LETTER_Z      = 7'd90;
    localparam int                NUM_POS       = 13;
    localparam logic [63:0]       TOP_POWER     = 64'd4052555153018976267;
    localparam int                NUM_DIRECTED  = 16;
    localparam int                NUM_RANDOM    = 200;
    localparam int                MAX_REPORTS   = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              ovf;
    } letter_beat_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [VALUE_W-1:0] value     = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CHAR_W-1:0]  char_code;
    logic               last_char;
    logic               overflow;

    letter_beat_t       exp_letters [$];
    logic [63:0]        pow27 [0:NUM_POS];
    bit                 quiet_phase = 1'b0;
    int                 mismatches  = 0;
    int                 chars_seen  = 0;
    int                 values_sent = 0;
    int                 ovf_values  = 0;
    int                 long_values = 0;

    // directed rows: an empty string means the predictor supplies the string
    logic [63:0] dir_value [NUM_DIRECTED] = '{
        64'd0, 64'd1, 64'd26, 64'd27, 64'd28, 64'd728, 64'd729, 64'd14,
        TOP_POWER - 64'd1, TOP_POWER, TOP_POWER + 64'd1, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000, 64'd12345678, 64'h0155_5555_5555_5555,
        64'h2AAA_AAAA_AAAA_AAAA
    };
    string dir_chars [NUM_DIRECTED] = '{
        "_", "_A", "_Z", "A_", "AA", "ZZ", "A__", "",
        "ZZZZZZZZZZZZZ", "A_____________", "ZZZZZZZZZZZZZ", "ZZZZZZZZZZZZZ",
        "ZZZZZZZZZZZZZ", "", "", ""
    };
    bit dir_ovf [NUM_DIRECTED] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0, 0
    };

    base27_number_to_letters_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last_char (last_char),
        .overflow  (overflow)
    );

    always #2 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("tb_top: timeout with %0d characters still expected", exp_letters.size());
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly short gaps, a few long ones, none at all during quiet stretches
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // append one expected character at the tail of the queue
    function automatic void queue_letter(letter_beat_t b);
        exp_letters = {exp_letters, b};
    endfunction

    // radix-27 conversion of one value into the queue of expected characters
    function automatic void predict_letters(logic [63:0] v);
        logic [CHAR_W-1:0] buf_chars [0:NUM_POS+1];
        logic [63:0]       rest;
        logic [63:0]       digit;
        int                n;
        bit                ovf;
        n    = 0;
        ovf  = 1'b0;
        rest = v;
        if (v == 64'd0)
        begin
            buf_chars[0] = UNDERSCORE;
            n = 1;
        end
        else if (v > pow27[NUM_POS])
        begin
            ovf = 1'b1;
            for (int k = 0; k < NUM_POS; k++)
                buf_chars[k] = LETTER_Z;
            n = NUM_POS;
        end
        else
        begin
            for (int d = NUM_POS; d >= 0; d--)
            begin
                if (v >= pow27[d])
                begin
                    digit = rest / pow27[d];
                    rest  = rest % pow27[d];
                    buf_chars[n] = (digit >= 1 && digit <= 26) ?
                                   LETTER_OFFSET + CHAR_W'(digit) : UNDERSCORE;
                    n++;
                end
            end
            // one-digit strings get a leading underscore
            if (n == 1)
            begin
                buf_chars[1] = buf_chars[0];
                buf_chars[0] = UNDERSCORE;
                n = 2;
            end
        end
        for (int k = 0; k < n; k++)
            queue_letter('{code: buf_chars[k], last: (k == n - 1), ovf: ovf});
    endfunction

    function automatic void expect_string(string s, bit ovf);
        for (int k = 0; k < s.len(); k++)
            queue_letter('{code: CHAR_W'(s[k]), last: (k == s.len() - 1), ovf: ovf});
    endfunction

    // drive one value after an idle gap; expectation is queued on the accepting edge
    task automatic send_value(logic [63:0] v, string typed, bit typed_ovf);
        int idle;
        idle = gap_len();
        repeat (idle)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            value    = rand64();
        end
        @(negedge clk);
        in_valid = 1'b1;
        value    = v;
        do
            @(posedge clk);
        while (!in_ready);
        if (typed.len() != 0)
            expect_string(typed, typed_ovf);
        else
            predict_letters(v);
        values_sent++;
        if (v > pow27[NUM_POS])
            ovf_values++;
        else if (v >= pow27[9])
            long_values++;
    endtask

    function automatic logic [63:0] random_value();
        int          kind;
        int          nd;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] v;
        kind = $urandom_range(0, 99);
        if (kind < 65)
        begin
            nd = $urandom_range(1, NUM_POS);
            lo = (nd == 1) ? 64'd1 : pow27[nd-1];
            hi = pow27[nd] - 64'd1;
            return lo + rand64() % (hi - lo + 64'd1);
        end
        else if (kind < 78)
        begin
            // digits biased to 0 and 26 to stress underscores and runs of Z
            nd = $urandom_range(2, NUM_POS);
            v  = 64'd0;
            for (int d = nd - 1; d >= 0; d--)
            begin
                case ($urandom_range(0, 2))
                    0: v = v * 64'd27;
                    1: v = v * 64'd27 + 64'd26;
                    default: v = v * 64'd27 + 64'($urandom_range(0, 26));
                endcase
                if (d == nd - 1 && v == 64'd0)
                    v = 64'd1;
            end
            return v;
        end
        else if (kind < 85)
            return TOP_POWER - 64'd3 + 64'($urandom_range(0, 6));
        else if (kind < 92)
            return 64'($urandom_range(0, 30));
        return rand64();
    endfunction

    // output side back pressure
    initial
    begin
        int stall;
        forever
        begin
            stall = gap_len();
            repeat (stall)
            begin
                @(negedge clk);
                out_ready = 1'b0;
            end
            repeat ($urandom_range(1, 8))
            begin
                @(negedge clk);
                out_ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        letter_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            chars_seen++;
            if (exp_letters.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("tb_top: unexpected char %0d last %0b ovf %0b",
                             char_code, last_char, overflow);
            end
            else
            begin
                want = exp_letters.pop_front();
                if (char_code !== want.code || last_char !== want.last ||
                    overflow !== want.ovf)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("tb_top: char mismatch, expected %0d/%0b/%0b got %0d/%0b/%0b",
                                 want.code, want.last, want.ovf,
                                 char_code, last_char, overflow);
                end
            end
        end
    end

    initial
    begin
        pow27[0] = 64'd1;
        for (int d = 1; d <= NUM_POS; d++)
            pow27[d] = pow27[d-1] * 64'd27;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_value(dir_value[i], dir_chars[i], dir_ovf[i]);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            // every so often run a stretch with no idling on either side
            quiet_phase = (i % 50) >= 35;
            send_value(random_value(), "", 1'b0);
        end
        quiet_phase = 1'b0;

        @(negedge clk);
        in_valid = 1'b0;

        while (exp_letters.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (exp_letters.size() != 0)
            mismatches += exp_letters.size();

        $display("tb_top: %0d values converted (%0d overflow, %0d with ten or more digits)",
                 values_sent, ovf_values, long_values);
        $display("tb_top: %0d characters checked, %0d mismatches", chars_seen, mismatches);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
